// File: design/h264rtp_pkg.sv
// Shared types and constants of the H.264 RTP FU-A packetiser.
package h264rtp_pkg;

	localparam int STAMP_W    = 32;
	localparam int TICKS_W    = 16;
	localparam int MTU_W      = 11;
	localparam int PT_W       = 7;
	localparam int CHAN_W     = 8;
	localparam int SEQ_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IDX_W      = 5;
	localparam int DIV_CNT_W  = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MTU     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PTYPE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SSRC    = 3'd5;

	// Configuration reset values.
	localparam logic [MTU_W-1:0]   MTU_RESET   = 11'd1400;
	localparam logic [STAMP_W-1:0] CYCLE_RESET = 32'hFFFF_FFFF;
	localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd90;
	localparam logic [PT_W-1:0]    PTYPE_RESET = 7'd96;

	// Packet format constants.
	localparam logic [MTU_W-1:0] MTU_MIN      = 11'd4;
	localparam logic [MTU_W-1:0] FU_OVERHEAD  = 11'd2;
	localparam logic [SEQ_W-1:0] RTP_HDR_LEN  = 16'd12;
	localparam logic [7:0]       FRAME_DOLLAR = 8'h24;
	localparam logic [7:0]       RTP_V2       = 8'h80;
	localparam logic [7:0]       FU_START     = 8'h80;
	localparam logic [7:0]       FU_END       = 8'h40;
	localparam logic [7:0]       NRI_MASK     = 8'h60;
	localparam logic [7:0]       TYPE_MASK    = 8'h1f;
	localparam logic [7:0]       FU_A_TYPE    = 8'd28;
	localparam logic [4:0]       NAL_TYPE_IDR = 5'd5;

	// Byte slots of one transmitted packet.
	localparam logic [IDX_W-1:0] IDX_DOLLAR   = 5'd0;
	localparam logic [IDX_W-1:0] IDX_CHANNEL  = 5'd1;
	localparam logic [IDX_W-1:0] IDX_LEN_HI   = 5'd2;
	localparam logic [IDX_W-1:0] IDX_LEN_LO   = 5'd3;
	localparam logic [IDX_W-1:0] IDX_VER      = 5'd4;
	localparam logic [IDX_W-1:0] IDX_MPT      = 5'd5;
	localparam logic [IDX_W-1:0] IDX_SEQ_HI   = 5'd6;
	localparam logic [IDX_W-1:0] IDX_SEQ_LO   = 5'd7;
	localparam logic [IDX_W-1:0] IDX_TS_3     = 5'd8;
	localparam logic [IDX_W-1:0] IDX_TS_2     = 5'd9;
	localparam logic [IDX_W-1:0] IDX_TS_1     = 5'd10;
	localparam logic [IDX_W-1:0] IDX_TS_0     = 5'd11;
	localparam logic [IDX_W-1:0] IDX_SSRC_3   = 5'd12;
	localparam logic [IDX_W-1:0] IDX_SSRC_2   = 5'd13;
	localparam logic [IDX_W-1:0] IDX_SSRC_1   = 5'd14;
	localparam logic [IDX_W-1:0] IDX_HDR_LAST = 5'd15;
	localparam logic [IDX_W-1:0] IDX_FU_IND   = 5'd16;
	localparam logic [IDX_W-1:0] IDX_FU_HDR   = 5'd17;
	localparam logic [IDX_W-1:0] IDX_DATA     = 5'd18;

	typedef logic [IDX_W-1:0] byte_idx_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_MUL  = 4'b0100,
		S_EMIT = 4'b1000
	} ctrl_state_t;

	typedef struct packed {
		logic      accept;
		logic      div_start;
		logic      mul;
		logic      emit;
		byte_idx_t idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic acc_out;
		logic acc_hdr;
		logic acc_fu;
		logic div_done;
		logic load_ok;
	} dp_status_t;

endpackage

// File: design/h264rtp_rem.sv
// Iterative remainder unit: one quotient bit per cycle, bypassed when no reduction is needed.
module h264rtp_rem (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [h264rtp_pkg::STAMP_W-1:0]   dividend,
	input  logic [h264rtp_pkg::STAMP_W-1:0]   divisor,
	output logic [h264rtp_pkg::STAMP_W-1:0]   rem,
	output logic                              done
);

	logic [h264rtp_pkg::STAMP_W-1:0]   rem_q;
	logic [h264rtp_pkg::STAMP_W-1:0]   dvd_q;
	logic [h264rtp_pkg::STAMP_W-1:0]   div_q;
	logic [h264rtp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                              busy_q;
	logic                              done_q;
	logic [h264rtp_pkg::STAMP_W:0]     trial;
	logic [h264rtp_pkg::STAMP_W:0]     trial_sub;
	logic                              bypass;

	// A zero period means no wrap; a stamp already below the period is its own remainder.
	assign bypass    = (divisor == '0) || (dividend < divisor);
	assign trial     = {rem_q, dvd_q[h264rtp_pkg::STAMP_W-1]};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !bypass;
			done_q <= bypass;
			cnt_q  <= h264rtp_pkg::DIV_CNT_W'(h264rtp_pkg::STAMP_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= bypass ? dividend : '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial_sub[h264rtp_pkg::STAMP_W-1:0];
			end else begin
				rem_q <= trial[h264rtp_pkg::STAMP_W-1:0];
			end
			dvd_q <= {dvd_q[h264rtp_pkg::STAMP_W-2:0], 1'b0};
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

// File: design/h264rtp_ctrl.sv
// Controller state machine: input acceptance, timestamp sequencing and byte slot stepping.
module h264rtp_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     nal_valid,
	output logic                     nal_stall,
	input  h264rtp_pkg::dp_status_t  st,
	output h264rtp_pkg::ctrl_cmd_t   cmd
);

	h264rtp_pkg::ctrl_state_t state_q, state_d;
	h264rtp_pkg::byte_idx_t   idx_q, idx_d;
	logic                     fu_q, fu_d;
	logic                     ready;
	logic                     accept;

	// The final data byte of a transaction frees the input in the cycle it is loaded.
	assign ready = (state_q == h264rtp_pkg::S_IDLE) ||
	               ((state_q == h264rtp_pkg::S_EMIT) && (idx_q == h264rtp_pkg::IDX_DATA) &&
	                st.load_ok);
	assign accept    = nal_valid && ready;
	assign nal_stall = !ready;

	assign cmd.accept    = accept;
	assign cmd.div_start = accept && st.acc_hdr;
	assign cmd.mul       = (state_q == h264rtp_pkg::S_MUL);
	assign cmd.emit      = (state_q == h264rtp_pkg::S_EMIT);
	assign cmd.idx       = idx_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		fu_d    = fu_q;
		unique case (state_q)
			h264rtp_pkg::S_IDLE: begin
				state_d = h264rtp_pkg::S_IDLE;
			end
			h264rtp_pkg::S_DIV: begin
				if (st.div_done) begin
					state_d = h264rtp_pkg::S_MUL;
				end
			end
			h264rtp_pkg::S_MUL: begin
				state_d = h264rtp_pkg::S_EMIT;
				idx_d   = h264rtp_pkg::IDX_DOLLAR;
			end
			h264rtp_pkg::S_EMIT: begin
				if (st.load_ok) begin
					if (idx_q == h264rtp_pkg::IDX_DATA) begin
						state_d = h264rtp_pkg::S_IDLE;
					end else if ((idx_q == h264rtp_pkg::IDX_HDR_LAST) && !fu_q) begin
						idx_d = h264rtp_pkg::IDX_DATA;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = h264rtp_pkg::S_IDLE;
			end
		endcase
		if (accept) begin
			if (!st.acc_out) begin
				state_d = h264rtp_pkg::S_IDLE;
			end else if (st.acc_hdr) begin
				state_d = h264rtp_pkg::S_DIV;
				fu_d    = st.acc_fu;
			end else begin
				state_d = h264rtp_pkg::S_EMIT;
				idx_d   = h264rtp_pkg::IDX_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= h264rtp_pkg::S_IDLE;
			idx_q   <= '0;
			fu_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			fu_q    <= fu_d;
		end
	end

endmodule

// File: design/h264rtp_datapath.sv
// Datapath: configuration, packetiser state, per-transaction job, timestamp and output register.
module h264rtp_datapath #(
	parameter int NAL_LENGTH_BITS = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  h264rtp_pkg::ctrl_cmd_t                cmd,
	output h264rtp_pkg::dp_status_t               st,
	input  logic [7:0]                            data_byte,
	input  logic                                  first_of_nal,
	input  logic [NAL_LENGTH_BITS-1:0]            nal_length,
	input  logic [h264rtp_pkg::STAMP_W-1:0]       stamp_ms,
	input  logic                                  cfg_we,
	input  logic [h264rtp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [h264rtp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                  pkt_valid,
	input  logic                                  pkt_stall,
	output logic [7:0]                            out_byte,
	output logic                                  last_of_packet,
	output logic                                  marker,
	output logic                                  key_frame
);

	localparam int NB = NAL_LENGTH_BITS;
	localparam int MW = h264rtp_pkg::MTU_W;

	// Configuration registers.
	logic [MW-1:0]                         mtu_q;
	logic [h264rtp_pkg::STAMP_W-1:0]       cycle_q;
	logic [h264rtp_pkg::TICKS_W-1:0]       ticks_q;
	logic [h264rtp_pkg::PT_W-1:0]          ptype_q;
	logic [h264rtp_pkg::CHAN_W-1:0]        chan_q;
	logic [h264rtp_pkg::STAMP_W-1:0]       ssrc_q;

	// Packetiser state.
	logic [NB-1:0]                         bo_q;
	logic [h264rtp_pkg::SEQ_W-1:0]         seq_q;
	logic [7:0]                            nh_q;
	logic                                  fs_q;
	logic [MW-1:0]                         pr_q;
	logic [h264rtp_pkg::STAMP_W-1:0]       ts_q;

	// Job latched at acceptance.
	logic [7:0]                            job_byte_q;
	logic [h264rtp_pkg::SEQ_W-1:0]         job_seq_q;
	logic [MW-1:0]                         job_plen_q;
	logic                                  job_hdr_mark_q;
	logic                                  job_hdr_key_q;
	logic                                  job_data_last_q;
	logic                                  job_data_mark_q;
	logic                                  job_data_key_q;
	logic [7:0]                            job_fu_ind_q;
	logic [7:0]                            job_fu_hdr_q;

	// Output register.
	logic                                  out_valid_q;
	logic [7:0]                            out_byte_q;
	logic                                  out_last_q;
	logic                                  out_mark_q;
	logic                                  out_key_q;

	logic [NB-1:0]                         len_eff;
	logic [MW-1:0]                         mtu_eff;
	logic [MW-1:0]                         chunk;
	logic [NB-1:0]                         chunk_ext;
	logic                                  first_big;
	logic                                  active;
	logic                                  frag_hdr;
	logic                                  data_go;
	logic [NB-1:0]                         rest;
	logic                                  rest_last;
	logic [MW-1:0]                         size;
	logic [MW-1:0]                         pr_eff;
	logic [NB:0]                           mark_sum;
	logic                                  c_mark;
	logic                                  c_key;
	logic [MW-1:0]                         pr_dec;
	logic [7:0]                            fu_hdr;
	logic [7:0]                            fu_ind;
	logic                                  b_key;
	logic [MW-1:0]                         b_pr;
	logic [h264rtp_pkg::STAMP_W-1:0]       rem;
	logic                                  rem_done;
	logic [h264rtp_pkg::STAMP_W+h264rtp_pkg::TICKS_W-1:0] product;
	logic [h264rtp_pkg::SEQ_W-1:0]         rtp_len;
	logic                                  load;
	logic [7:0]                            sel_byte;
	logic                                  sel_data;

	h264rtp_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (stamp_ms),
		.divisor  (cycle_q),
		.rem      (rem),
		.done     (rem_done)
	);

	// Decision for the item presented at the input.
	assign len_eff   = (nal_length == '0) ? NB'(1) : nal_length;
	assign mtu_eff   = (mtu_q < h264rtp_pkg::MTU_MIN) ? h264rtp_pkg::MTU_MIN : mtu_q;
	assign chunk     = mtu_eff - h264rtp_pkg::FU_OVERHEAD;
	assign chunk_ext = NB'(chunk);
	assign first_big = len_eff > chunk_ext;
	assign active    = (bo_q != '0) && (bo_q < len_eff);
	assign frag_hdr  = active && (pr_q == '0) && fs_q;
	assign data_go   = active && ((pr_q != '0) || fs_q);
	assign rest      = len_eff - bo_q;
	assign rest_last = rest <= chunk_ext;
	assign size      = rest_last ? rest[MW-1:0] : chunk;
	assign pr_eff    = (pr_q == '0) ? size : pr_q;
	assign mark_sum  = {1'b0, bo_q} + (NB+1)'(pr_eff);
	assign c_mark    = mark_sum >= {1'b0, len_eff};
	assign c_key     = !fs_q && ((nh_q[4:0]) == h264rtp_pkg::NAL_TYPE_IDR);
	assign pr_dec    = pr_eff - 1'b1;
	assign fu_hdr    = (rest_last ? h264rtp_pkg::FU_END :
	                   ((bo_q == NB'(1)) ? h264rtp_pkg::FU_START : 8'h00)) |
	                   (nh_q & h264rtp_pkg::TYPE_MASK);
	assign fu_ind    = (nh_q & h264rtp_pkg::NRI_MASK) + h264rtp_pkg::FU_A_TYPE;
	assign b_key     = (data_byte[4:0] == h264rtp_pkg::NAL_TYPE_IDR);
	assign b_pr      = len_eff[MW-1:0] - 1'b1;

	assign st.acc_out  = first_of_nal ? !first_big : data_go;
	assign st.acc_hdr  = first_of_nal ? !first_big : frag_hdr;
	assign st.acc_fu   = !first_of_nal && frag_hdr;
	assign st.div_done = rem_done;
	assign st.load_ok  = !out_valid_q || !pkt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q   <= h264rtp_pkg::MTU_RESET;
			cycle_q <= h264rtp_pkg::CYCLE_RESET;
			ticks_q <= h264rtp_pkg::TICKS_RESET;
			ptype_q <= h264rtp_pkg::PTYPE_RESET;
			chan_q  <= '0;
			ssrc_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				h264rtp_pkg::CFG_MTU:     mtu_q   <= cfg_data[MW-1:0];
				h264rtp_pkg::CFG_CYCLE:   cycle_q <= cfg_data[h264rtp_pkg::STAMP_W-1:0];
				h264rtp_pkg::CFG_TICKS:   ticks_q <= cfg_data[h264rtp_pkg::TICKS_W-1:0];
				h264rtp_pkg::CFG_PTYPE:   ptype_q <= cfg_data[h264rtp_pkg::PT_W-1:0];
				h264rtp_pkg::CFG_CHANNEL: chan_q  <= cfg_data[h264rtp_pkg::CHAN_W-1:0];
				h264rtp_pkg::CFG_SSRC:    ssrc_q  <= cfg_data[h264rtp_pkg::STAMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign product = rem * ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bo_q  <= '0;
			seq_q <= '0;
			nh_q  <= '0;
			fs_q  <= 1'b0;
			pr_q  <= '0;
			ts_q  <= '0;
		end else begin
			if (cmd.mul) begin
				ts_q <= product[h264rtp_pkg::STAMP_W-1:0];
			end
			if (cmd.accept) begin
				if (first_of_nal) begin
					nh_q <= data_byte;
					bo_q <= NB'(1);
					fs_q <= first_big;
					if (first_big) begin
						pr_q <= '0;
					end else begin
						pr_q  <= b_pr;
						seq_q <= seq_q + 1'b1;
					end
				end else if (data_go) begin
					pr_q <= pr_dec;
					bo_q <= bo_q + 1'b1;
					if (frag_hdr) begin
						seq_q <= seq_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			job_byte_q      <= data_byte;
			job_seq_q       <= seq_q;
			job_plen_q      <= first_of_nal ? len_eff[MW-1:0] : size + h264rtp_pkg::FU_OVERHEAD;
			job_hdr_mark_q  <= first_of_nal ? 1'b1 : rest_last;
			job_hdr_key_q   <= first_of_nal ? b_key : 1'b0;
			job_data_last_q <= first_of_nal ? (b_pr == '0) : (pr_dec == '0);
			job_data_mark_q <= first_of_nal ? 1'b1 : c_mark;
			job_data_key_q  <= first_of_nal ? b_key : c_key;
			job_fu_ind_q    <= fu_ind;
			job_fu_hdr_q    <= fu_hdr;
		end
	end

	assign rtp_len = h264rtp_pkg::SEQ_W'(job_plen_q) + h264rtp_pkg::RTP_HDR_LEN;

	always_comb begin
		sel_data = 1'b0;
		unique case (cmd.idx)
			h264rtp_pkg::IDX_DOLLAR:  sel_byte = h264rtp_pkg::FRAME_DOLLAR;
			h264rtp_pkg::IDX_CHANNEL: sel_byte = chan_q;
			h264rtp_pkg::IDX_LEN_HI:  sel_byte = rtp_len[15:8];
			h264rtp_pkg::IDX_LEN_LO:  sel_byte = rtp_len[7:0];
			h264rtp_pkg::IDX_VER:     sel_byte = h264rtp_pkg::RTP_V2;
			h264rtp_pkg::IDX_MPT:     sel_byte = {job_hdr_mark_q, ptype_q};
			h264rtp_pkg::IDX_SEQ_HI:  sel_byte = job_seq_q[15:8];
			h264rtp_pkg::IDX_SEQ_LO:  sel_byte = job_seq_q[7:0];
			h264rtp_pkg::IDX_TS_3:    sel_byte = ts_q[31:24];
			h264rtp_pkg::IDX_TS_2:    sel_byte = ts_q[23:16];
			h264rtp_pkg::IDX_TS_1:    sel_byte = ts_q[15:8];
			h264rtp_pkg::IDX_TS_0:    sel_byte = ts_q[7:0];
			h264rtp_pkg::IDX_SSRC_3:  sel_byte = ssrc_q[31:24];
			h264rtp_pkg::IDX_SSRC_2:  sel_byte = ssrc_q[23:16];
			h264rtp_pkg::IDX_SSRC_1:  sel_byte = ssrc_q[15:8];
			h264rtp_pkg::IDX_HDR_LAST: sel_byte = ssrc_q[7:0];
			h264rtp_pkg::IDX_FU_IND:  sel_byte = job_fu_ind_q;
			h264rtp_pkg::IDX_FU_HDR:  sel_byte = job_fu_hdr_q;
			default: begin
				sel_byte = job_byte_q;
				sel_data = 1'b1;
			end
		endcase
	end

	assign load = cmd.emit && st.load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!pkt_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= sel_byte;
			out_last_q <= sel_data && job_data_last_q;
			out_mark_q <= sel_data ? job_data_mark_q : job_hdr_mark_q;
			out_key_q  <= sel_data ? job_data_key_q : job_hdr_key_q;
		end
	end

	assign pkt_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign last_of_packet = out_last_q;
	assign marker         = out_mark_q;
	assign key_frame      = out_key_q;

endmodule

// File: design/h264_rtp_fua_packetizer.sv
// Top level of the H.264 RTP FU-A packetiser with interleaved framing.
//
//  Channel  Handshake              Carries
//  nal      nal_valid / nal_stall  data_byte, first_of_nal, nal_length, stamp_ms
//  pkt      pkt_valid / pkt_stall  out_byte, last_of_packet, marker, key_frame
//  cfg      cfg_we                 cfg_index, cfg_data
//
// A NAL byte continuing an open packet has no header; the next follows at once unless pkt stalls.
// A byte that opens a packet first waits for the remainder unit and the multiplier, then emits
// the 18 header bytes (16 without FU bytes); the remainder unit is bypassed when the stamp is
// below cycle_ms and otherwise resolves one bit per cycle.
// Reset returns the packetiser state and the configuration to their defaults.
// A stall on pkt holds the output register, and nal is stalled while a packet header is built.
module h264_rtp_fua_packetizer #(
	parameter int NAL_LENGTH_BITS = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  nal_valid,
	output logic                                  nal_stall,
	input  logic [7:0]                            data_byte,
	input  logic                                  first_of_nal,
	input  logic [NAL_LENGTH_BITS-1:0]            nal_length,
	input  logic [h264rtp_pkg::STAMP_W-1:0]       stamp_ms,
	output logic                                  pkt_valid,
	input  logic                                  pkt_stall,
	output logic [7:0]                            out_byte,
	output logic                                  last_of_packet,
	output logic                                  marker,
	output logic                                  key_frame,
	input  logic                                  cfg_we,
	input  logic [h264rtp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [h264rtp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	h264rtp_pkg::ctrl_cmd_t  cmd;
	h264rtp_pkg::dp_status_t st;

	h264rtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.nal_valid (nal_valid),
		.nal_stall (nal_stall),
		.st        (st),
		.cmd       (cmd)
	);

	h264rtp_datapath #(
		.NAL_LENGTH_BITS (NAL_LENGTH_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.data_byte      (data_byte),
		.first_of_nal   (first_of_nal),
		.nal_length     (nal_length),
		.stamp_ms       (stamp_ms),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pkt_valid      (pkt_valid),
		.pkt_stall      (pkt_stall),
		.out_byte       (out_byte),
		.last_of_packet (last_of_packet),
		.marker         (marker),
		.key_frame      (key_frame)
	);

endmodule

// File: design/h264rtp_checker.sv
// Port-level checker of the packetiser and its bind to the top level.
module h264rtp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       nal_valid,
	input logic       nal_stall,
	input logic       pkt_valid,
	input logic       pkt_stall,
	input logic [7:0] out_byte,
	input logic       last_of_packet,
	input logic       marker,
	input logic       key_frame
);

	// A stalled output transaction keeps its valid and its payload.
	a_pkt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_stall |=> pkt_valid && $stable(out_byte) &&
		$stable(last_of_packet) && $stable(marker) && $stable(key_frame))
		else $error("pkt payload changed under stall");

	// After reset is sampled low, nothing is offered and the input is not held off.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !pkt_valid && !nal_stall)
		else $error("activity during reset");

	// The input is held off only after a transaction was taken, or while the output is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(nal_stall) |-> $past(nal_valid && !nal_stall) || (pkt_valid && pkt_stall))
		else $error("nal stall raised without cause");

endmodule

bind h264_rtp_fua_packetizer h264rtp_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.nal_valid      (nal_valid),
	.nal_stall      (nal_stall),
	.pkt_valid      (pkt_valid),
	.pkt_stall      (pkt_stall),
	.out_byte       (out_byte),
	.last_of_packet (last_of_packet),
	.marker         (marker),
	.key_frame      (key_frame)
);
